// ----- rtl/gamma_bitplane_packer_unit_defines.svh -----
// Assertion macros shared by the gamma bitplane packer checker.
`ifndef GAMMA_BITPLANE_PACKER_UNIT_DEFINES_SVH
`define GAMMA_BITPLANE_PACKER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GBP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gbp checker: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define GBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gbp checker: next-cycle property failed");

`endif

// ----- rtl/gbp_pkg.sv -----
// Shared constants, types and functions of the gamma bitplane packer.
package gbp_pkg;

    localparam int PWM_BITS    = 10;
    localparam int PLANE_WORDS = 2;
    localparam int CURVES      = 8;

    localparam int LEVELS    = 256;
    localparam int SLOTS     = 5;
    localparam int SLOT_BITS = 6;
    localparam int CHANNELS  = 6;
    localparam int CURVE_W   = 3;
    localparam int LEVEL_W   = 8;
    localparam int VALUE_W   = 10;
    localparam int PIXEL_W   = 24;
    localparam int WORD_W    = SLOTS * SLOT_BITS;

    localparam int TABLE_DEPTH  = CURVES * LEVELS;
    localparam int ADDR_W       = $clog2(TABLE_DEPTH);
    localparam int PLANE_OFFSET = SLOTS * PLANE_WORDS - PWM_BITS;
    localparam int BIT_IDX_W    = $clog2(VALUE_W);
    localparam int WIDX_W       = (PLANE_WORDS > 1) ? $clog2(PLANE_WORDS) : 1;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [0:0] {
        OP_LOAD    = 1'b0,
        OP_CONVERT = 1'b1
    } op_t;

    typedef logic [CHANNELS-1:0][VALUE_W-1:0] levels_t;

    typedef struct packed {
        logic    valid;
        levels_t levels;
    } push_t;

    typedef struct packed {
        logic              valid;
        logic [QCNT_W-1:0] count;
    } q_status_t;

    function automatic logic curve_ok(logic [CURVE_W-1:0] curve);
        return int'(curve) < CURVES;
    endfunction

    function automatic logic [ADDR_W-1:0] lut_addr(logic [CURVE_W-1:0] curve,
                                                   logic [LEVEL_W-1:0] level);
        return ADDR_W'(int'(curve) * LEVELS + int'(level));
    endfunction

    // Slot l of word w carries plane SLOTS*w+l of all six channels.
    function automatic logic [WORD_W-1:0] pack_word(levels_t lv, logic [WIDX_W-1:0] w);
        logic [WORD_W-1:0] word;
        int plane;
        int b;
        word = '0;
        for (int l = 0; l < SLOTS; l++) begin
            for (int c = 0; c < CHANNELS; c++) begin
                plane = SLOTS * int'(w) + l;
                b = plane - PLANE_OFFSET;
                if (b >= 0 && b < VALUE_W) begin
                    word[SLOT_BITS * l + c] = lv[c][BIT_IDX_W'(b)];
                end
            end
        end
        return word;
    endfunction

endpackage

// ----- rtl/gbp_ram.sv -----
// Generic RAM with one write port and two registered read ports.
module gbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a <= mem_reg[raddr_a];
        rdata_b <= mem_reg[raddr_b];
    end

endmodule

// ----- rtl/gbp_front.sv -----
// Front end: accepts items, writes table entries and looks up six channel levels.
module gbp_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [gbp_pkg::CURVE_W-1:0]    gamma_select,
    input  logic                           push,
    output logic                           full,
    input  logic                           operation,
    input  logic [gbp_pkg::CURVE_W-1:0]    lut_curve,
    input  logic [gbp_pkg::LEVEL_W-1:0]    lut_level,
    input  logic [gbp_pkg::VALUE_W-1:0]    lut_value,
    input  logic [gbp_pkg::PIXEL_W-1:0]    top_pixel,
    input  logic [gbp_pkg::PIXEL_W-1:0]    bottom_pixel,
    input  gbp_pkg::q_status_t             q_status,
    output gbp_pkg::push_t                 q_push
);

    logic [gbp_pkg::CURVE_W-1:0]   select_reg;
    logic                          pending_reg;
    logic                          pending_next;
    logic                          zero_reg;
    logic                          zero_next;
    logic                          accept;
    logic                          table_we;
    logic [gbp_pkg::ADDR_W-1:0]    waddr;
    logic [gbp_pkg::LEVEL_W-1:0]   chan [gbp_pkg::CHANNELS];
    logic [gbp_pkg::ADDR_W-1:0]    raddr [gbp_pkg::CHANNELS];
    gbp_pkg::levels_t              rdata;

    // Credit check: the queue must have room for a lookup still in flight.
    assign full = ({1'b0, q_status.count} + (gbp_pkg::QCNT_W + 1)'(pending_reg))
                  >= (gbp_pkg::QCNT_W + 1)'(gbp_pkg::QDEPTH);
    assign accept = push && !full;

    assign table_we = accept && (operation == gbp_pkg::OP_LOAD)
                      && gbp_pkg::curve_ok(lut_curve);
    assign waddr = gbp_pkg::lut_addr(lut_curve, lut_level);

    // Channel order of the plane slots: low byte, high byte, middle byte.
    assign chan[0] = top_pixel[7:0];
    assign chan[1] = top_pixel[23:16];
    assign chan[2] = top_pixel[15:8];
    assign chan[3] = bottom_pixel[7:0];
    assign chan[4] = bottom_pixel[23:16];
    assign chan[5] = bottom_pixel[15:8];

    always_comb
    begin
        for (int c = 0; c < gbp_pkg::CHANNELS; c++)
        begin
            raddr[c] = gbp_pkg::lut_addr(select_reg, chan[c]);
        end
    end

    // Three identical copies of the table give six reads in one cycle.
    for (genvar g = 0; g < gbp_pkg::CHANNELS / 2; g++)
    begin : g_copy
        gbp_ram #(
            .WIDTH (gbp_pkg::VALUE_W),
            .DEPTH (gbp_pkg::TABLE_DEPTH)
        ) u_table (
            .clk     (clk),
            .we      (table_we),
            .waddr   (waddr),
            .wdata   (lut_value),
            .raddr_a (raddr[2*g]),
            .raddr_b (raddr[2*g+1]),
            .rdata_a (rdata[2*g]),
            .rdata_b (rdata[2*g+1])
        );
    end

    assign pending_next = accept && (operation == gbp_pkg::OP_CONVERT);
    assign zero_next    = !gbp_pkg::curve_ok(select_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            select_reg  <= '0;
            pending_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                select_reg <= gamma_select;
            end
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg <= zero_next;
    end

    assign q_push.valid  = pending_reg;
    assign q_push.levels = zero_reg ? '0 : rdata;

endmodule

// ----- rtl/gbp_fifo.sv -----
// Short level queue between the front end and the word packer.
module gbp_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  gbp_pkg::push_t     q_push,
    input  logic               q_pop,
    output gbp_pkg::levels_t   head,
    output gbp_pkg::q_status_t q_status
);

    gbp_pkg::levels_t            entry_reg [gbp_pkg::QDEPTH];
    logic [gbp_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [gbp_pkg::QPTR_W-1:0]  wr_ptr_next;
    logic [gbp_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [gbp_pkg::QPTR_W-1:0]  rd_ptr_next;
    logic [gbp_pkg::QCNT_W-1:0]  count_reg;
    logic [gbp_pkg::QCNT_W-1:0]  count_next;

    function automatic logic [gbp_pkg::QPTR_W-1:0] bump(logic [gbp_pkg::QPTR_W-1:0] p);
        return (p == gbp_pkg::QPTR_W'(gbp_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = q_push.valid ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = q_pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (q_push.valid && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!q_push.valid && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push.valid)
        begin
            entry_reg[wr_ptr_reg] <= q_push.levels;
        end
    end

    assign head           = entry_reg[rd_ptr_reg];
    assign q_status.valid = (count_reg != '0);
    assign q_status.count = count_reg;

endmodule

// ----- rtl/gbp_back.sv -----
// Back end: slices queued levels into plane words and holds the result register.
module gbp_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gbp_pkg::levels_t              head,
    input  gbp_pkg::q_status_t            q_status,
    output logic                          q_pop,
    output logic                          empty,
    input  logic                          pop,
    output logic [gbp_pkg::WORD_W-1:0]    plane_word,
    output logic                          segment,
    output logic                          last
);

    logic [gbp_pkg::WIDX_W-1:0]  widx_reg;
    logic [gbp_pkg::WIDX_W-1:0]  widx_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [gbp_pkg::WORD_W-1:0]  word_reg;
    logic                        segment_reg;
    logic                        last_reg;
    logic                        load_out;
    logic                        widx_last;

    // The result register takes a new word when it is free or being taken.
    assign load_out  = q_status.valid && (!out_valid_reg || pop);
    assign widx_last = (widx_reg == gbp_pkg::WIDX_W'(gbp_pkg::PLANE_WORDS - 1));
    assign q_pop     = load_out && widx_last;

    always_comb
    begin
        widx_next = widx_reg;
        if (load_out)
        begin
            widx_next = widx_last ? '0 : widx_reg + 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            widx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            widx_reg      <= widx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            word_reg    <= gbp_pkg::pack_word(head, widx_reg);
            segment_reg <= widx_reg[0];
            last_reg    <= widx_last;
        end
    end

    assign empty      = !out_valid_reg;
    assign plane_word = word_reg;
    assign segment    = segment_reg;
    assign last       = last_reg;

endmodule

// ----- rtl/gamma_bitplane_packer_unit.sv -----
// Top level of the gamma bitplane packer: front end, level queue and word packer.
//
//   Channel  | Handshake          | Carries
//   ---------+--------------------+-----------------------------------------------
//   config   | cfg_write          | gamma_select, the curve used for conversion
//   input    | push / full        | operation, lut_curve/level/value, two pixels
//   result   | pop / empty        | plane_word, segment, last
//
// A pixel pair gives PLANE_WORDS result words (two here), one per cycle while
// pop takes each word, through the single-word result register. A load item
// gives no result. The first word of a pair passes the table read, the queue
// entry and the result register before it is on the result ports.
// Reset clears control state only; table entries hold nothing until loaded.
// full rises when the four-entry level queue, counting a lookup in flight,
// is out of room; the packer stalls alone while pop stays low.
module gamma_bitplane_packer_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [gbp_pkg::CURVE_W-1:0]    gamma_select,
    input  logic                           push,
    output logic                           full,
    input  logic                           operation,
    input  logic [gbp_pkg::CURVE_W-1:0]    lut_curve,
    input  logic [gbp_pkg::LEVEL_W-1:0]    lut_level,
    input  logic [gbp_pkg::VALUE_W-1:0]    lut_value,
    input  logic [gbp_pkg::PIXEL_W-1:0]    top_pixel,
    input  logic [gbp_pkg::PIXEL_W-1:0]    bottom_pixel,
    output logic                           empty,
    input  logic                           pop,
    output logic [gbp_pkg::WORD_W-1:0]     plane_word,
    output logic                           segment,
    output logic                           last
);

    // Lookup results flow from the front end into the queue.
    gbp_pkg::push_t     q_push;
    // Queue fill level, used by the front end for credit and by the packer.
    gbp_pkg::q_status_t q_status;
    // The levels of the oldest queued pixel pair.
    gbp_pkg::levels_t   head;
    // The packer retires a queue entry after its final word.
    logic               q_pop;

    // The front end decodes each item: a load writes all table copies, a
    // conversion reads six levels whose registered data is then pushed into the queue.
    gbp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .gamma_select (gamma_select),
        .push         (push),
        .full         (full),
        .operation    (operation),
        .lut_curve    (lut_curve),
        .lut_level    (lut_level),
        .lut_value    (lut_value),
        .top_pixel    (top_pixel),
        .bottom_pixel (bottom_pixel),
        .q_status     (q_status),
        .q_push       (q_push)
    );

    // The queue decouples the front end from the multi-word back end.
    gbp_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_push   (q_push),
        .q_pop    (q_pop),
        .head     (head),
        .q_status (q_status)
    );

    // The packer emits one plane word per cycle into its result register while pop takes each word.
    gbp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_status   (q_status),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .plane_word (plane_word),
        .segment    (segment),
        .last       (last)
    );

endmodule

// ----- rtl/gbp_checker.sv -----
// Port-level checker for the gamma bitplane packer, bound to the top level.
`include "gamma_bitplane_packer_unit_defines.svh"

module gbp_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        empty,
    input logic                        pop,
    input logic [gbp_pkg::WORD_W-1:0]  plane_word,
    input logic                        segment,
    input logic                        last
);

    // Words of one pixel pair come out without a gap once the first is taken.
    `GBP_ASSERT_NEXT(a_no_gap_in_pair, clk, rst_n, pop && !empty && !last, !empty)

    // Within a pair the segment index counts up by one.
    `GBP_ASSERT_NEXT(a_segment_steps, clk, rst_n, pop && !empty && !last,
                     segment == ($past(segment) + 1'b1))

    // A new pair starts with segment zero.
    `GBP_ASSERT_NEXT(a_pair_starts_at_zero, clk, rst_n, pop && !empty && last,
                     empty || (segment == 1'b0))

    // A waiting word is held until it is taken.
    `GBP_ASSERT_NEXT(a_word_held, clk, rst_n, !empty && !pop,
                     !empty && $stable(plane_word) && $stable(last))

endmodule

bind gamma_bitplane_packer_unit gbp_checker u_gbp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop        (pop),
    .plane_word (plane_word),
    .segment    (segment),
    .last       (last)
);
